>>> sv/fqlt_pkg.sv
package fqlt_pkg;

   localparam int NUM_LATCHES    = 64;
   localparam int NUM_REQUESTERS = 32;

   localparam int LATCH_W  = 6;
   localparam int REQ_W    = 5;
   localparam int LATCH_AW = $clog2(NUM_LATCHES);
   localparam int REQ_AW   = $clog2(NUM_REQUESTERS);

   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      STATUS_GRANTED  = 3'd0,
      STATUS_QUEUED   = 3'd1,
      STATUS_REJECTED = 3'd2,
      STATUS_FREED    = 3'd3,
      STATUS_HANDED   = 3'd4
   } status_type;

   typedef struct packed {
      logic               cmd;
      logic [LATCH_W-1:0] latch_id;
      logic [REQ_W-1:0]   requester_id;
      logic               also_release;
      logic [LATCH_W-1:0] release_latch_id;
   } req_type;

   typedef struct packed {
      logic [LATCH_W-1:0] latch_out;
      status_type         status;
      logic               wake_valid;
      logic [REQ_W-1:0]   wake_id;
      logic               last;
   } rsp_type;

endpackage

>>> sv/fqlt_ram.sv
module fqlt_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/fifo_queued_latch_table.sv
// Table of FIFO-queued latches with hand-over to the oldest waiter. Each request
// transaction is one latch operation, or an acquire followed by a release of a second
// latch (two response transactions, the second flagged last, unless the acquire is
// rejected). The block takes one request at a time: req_stall is high from acceptance
// until the final response is loaded into the output register, which may be held by
// rsp_stall. Each operation runs through the shared latch-operation sequencer: a
// registered read of the head/tail pointer memories, then a dependent registered read
// of the waiter link memory, then the update.
// No clearing pass is needed after reset.
module fifo_queued_latch_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fqlt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fqlt_pkg::rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_LINK,
      S_APPLY
   } state_type;

   state_type                          state_ff, state_in;
   logic [fqlt_pkg::LATCH_AW-1:0]      lat_ff, lat_in;
   logic [fqlt_pkg::LATCH_AW-1:0]      rel_lat_ff, rel_lat_in;
   logic                               kind_ff, kind_in;
   logic [fqlt_pkg::REQ_AW-1:0]        rqr_ff, rqr_in;
   logic                               also_ff, also_in;
   logic [fqlt_pkg::NUM_LATCHES-1:0]   busy_ff, busy_in;
   logic [fqlt_pkg::NUM_LATCHES-1:0]   nonempty_ff, nonempty_in;
   logic [fqlt_pkg::NUM_REQUESTERS-1:0] waiting_ff, waiting_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   fqlt_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                               head_we, tail_we, link_we;
   logic [fqlt_pkg::REQ_AW-1:0]        head_wdata, tail_wdata, link_wdata;
   logic [fqlt_pkg::REQ_AW-1:0]        link_waddr;
   logic [fqlt_pkg::REQ_AW-1:0]        head_q, tail_q, link_q;

   logic                               accept, out_free;

   fqlt_ram #(.DEPTH(fqlt_pkg::NUM_LATCHES), .WIDTH(fqlt_pkg::REQ_AW)) u_head (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (lat_ff),
      .wr_data (head_wdata),
      .rd_addr (lat_ff),
      .rd_data (head_q)
   );

   fqlt_ram #(.DEPTH(fqlt_pkg::NUM_LATCHES), .WIDTH(fqlt_pkg::REQ_AW)) u_tail (
      .clock   (clock),
      .wr_en   (tail_we),
      .wr_addr (lat_ff),
      .wr_data (tail_wdata),
      .rd_addr (lat_ff),
      .rd_data (tail_q)
   );

   fqlt_ram #(.DEPTH(fqlt_pkg::NUM_REQUESTERS), .WIDTH(fqlt_pkg::REQ_AW)) u_link (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (head_q),
      .rd_data (link_q)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      lat_in       = lat_ff;
      rel_lat_in   = rel_lat_ff;
      kind_in      = kind_ff;
      rqr_in       = rqr_ff;
      also_in      = also_ff;
      busy_in      = busy_ff;
      nonempty_in  = nonempty_ff;
      waiting_in   = waiting_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      head_we      = 1'b0;
      tail_we      = 1'b0;
      link_we      = 1'b0;
      head_wdata   = rqr_ff;
      tail_wdata   = rqr_ff;
      link_wdata   = rqr_ff;
      link_waddr   = tail_q;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lat_in     = req_payload.latch_id[fqlt_pkg::LATCH_AW-1:0];
               rel_lat_in = req_payload.release_latch_id[fqlt_pkg::LATCH_AW-1:0];
               kind_in    = req_payload.cmd;
               rqr_in     = req_payload.requester_id[fqlt_pkg::REQ_AW-1:0];
               also_in    = req_payload.also_release;
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_LINK;
         end
         S_LINK: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.latch_out  = fqlt_pkg::LATCH_W'(lat_ff);
               rsp_in.wake_valid = 1'b0;
               rsp_in.wake_id    = '0;
               rsp_in.last       = 1'b1;
               state_in          = S_IDLE;
               if (kind_ff == fqlt_pkg::CMD_RELEASE) begin
                  if (nonempty_ff[lat_ff]) begin
                     waiting_in[head_q] = 1'b0;
                     if (head_q == tail_q) begin
                        nonempty_in[lat_ff] = 1'b0;
                     end else begin
                        head_we    = 1'b1;
                        head_wdata = link_q;
                     end
                     busy_in[lat_ff]   = 1'b1;
                     rsp_in.status     = fqlt_pkg::STATUS_HANDED;
                     rsp_in.wake_valid = 1'b1;
                     rsp_in.wake_id    = fqlt_pkg::REQ_W'(head_q);
                  end else begin
                     busy_in[lat_ff] = 1'b0;
                     rsp_in.status   = fqlt_pkg::STATUS_FREED;
                  end
               end else if (waiting_ff[rqr_ff]) begin
                  rsp_in.status = fqlt_pkg::STATUS_REJECTED;
               end else begin
                  if (busy_ff[lat_ff]) begin
                     waiting_in[rqr_ff] = 1'b1;
                     tail_we            = 1'b1;
                     if (nonempty_ff[lat_ff]) begin
                        link_we = 1'b1;
                     end else begin
                        head_we             = 1'b1;
                        nonempty_in[lat_ff] = 1'b1;
                     end
                     rsp_in.status = fqlt_pkg::STATUS_QUEUED;
                  end else begin
                     busy_in[lat_ff] = 1'b1;
                     rsp_in.status   = fqlt_pkg::STATUS_GRANTED;
                  end
                  if (also_ff) begin
                     rsp_in.last = 1'b0;
                     lat_in      = rel_lat_ff;
                     kind_in     = fqlt_pkg::CMD_RELEASE;
                     state_in    = S_LOOK;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         nonempty_ff  <= '0;
         waiting_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         nonempty_ff  <= nonempty_in;
         waiting_ff   <= waiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lat_ff     <= lat_in;
      rel_lat_ff <= rel_lat_in;
      kind_ff    <= kind_in;
      rqr_ff     <= rqr_in;
      also_ff    <= also_in;
      rsp_ff     <= rsp_in;
   end

   a_queue_implies_busy: assert property (@(posedge clock) disable iff (reset)
      (nonempty_ff & ~busy_ff) == '0)
      else $error("latch has waiters but is not busy");

   a_head_is_waiting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && kind_ff == fqlt_pkg::CMD_RELEASE && nonempty_ff[lat_ff])
      |-> waiting_ff[head_q])
      else $error("queue head is not marked waiting");

   a_wake_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.wake_valid == (rsp_ff.status == fqlt_pkg::STATUS_HANDED)))
      else $error("wake flag disagrees with status");

   a_first_of_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |->
      (rsp_ff.status == fqlt_pkg::STATUS_GRANTED || rsp_ff.status == fqlt_pkg::STATUS_QUEUED))
      else $error("non-final response is not an acquire result");

endmodule
